// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DUIV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, disabled while reset is asserted
`define DUIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== design/duiv_pkg.sv =====
// types, constants and header lookup functions of the data url image validator
`default_nettype none

package duiv_pkg;

    localparam int CHAR_W      = 16;
    localparam int LEN_W       = 21;
    localparam int TYPE_COUNT  = 5;
    localparam int HDR_MAX_LEN = 23;
    localparam int HDR_POS_W   = 5;

    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [TYPE_COUNT-1:0] t_cand;
    typedef logic [HDR_POS_W-1:0]  t_hdr_pos;
    typedef logic [2:0]            t_type;

    localparam t_len     LENGTH_MAX      = {LEN_W{1'b1}};
    localparam t_len     MAX_CHARS_RESET = 21'd1500000;
    localparam t_hdr_pos HDR_POS_MAX     = {HDR_POS_W{1'b1}};

    // image type codes, one candidate bit each
    localparam t_type TYPE_JPEG = 3'd0;
    localparam t_type TYPE_PNG  = 3'd1;
    localparam t_type TYPE_GIF  = 3'd2;
    localparam t_type TYPE_WEBP = 3'd3;
    localparam t_type TYPE_BMP  = 3'd4;

    // ascii code units used by the checks
    localparam t_char CH_COMMA   = 16'h002C;
    localparam t_char CH_EQUAL   = 16'h003D;
    localparam t_char CH_PLUS    = 16'h002B;
    localparam t_char CH_SLASH   = 16'h002F;
    localparam t_char CH_DIGIT_0 = 16'h0030;
    localparam t_char CH_DIGIT_9 = 16'h0039;
    localparam t_char CH_UPPER_A = 16'h0041;
    localparam t_char CH_UPPER_Z = 16'h005A;
    localparam t_char CH_LOWER_A = 16'h0061;
    localparam t_char CH_LOWER_Z = 16'h007A;
    localparam t_char CASE_DELTA = 16'h0020;

    // full headers, shorter ones padded at the top
    localparam logic [HDR_MAX_LEN*8-1:0] HDR_STR_JPEG = "data:image/jpeg;base64,";
    localparam logic [HDR_MAX_LEN*8-1:0] HDR_STR_PNG  = "data:image/png;base64,";
    localparam logic [HDR_MAX_LEN*8-1:0] HDR_STR_GIF  = "data:image/gif;base64,";
    localparam logic [HDR_MAX_LEN*8-1:0] HDR_STR_WEBP = "data:image/webp;base64,";
    localparam logic [HDR_MAX_LEN*8-1:0] HDR_STR_BMP  = "data:image/bmp;base64,";

    function automatic t_hdr_pos hdr_len(input t_type k);
        t_hdr_pos len;
        case (k)
            TYPE_JPEG: len = 5'd23;
            TYPE_PNG:  len = 5'd22;
            TYPE_GIF:  len = 5'd22;
            TYPE_WEBP: len = 5'd23;
            TYPE_BMP:  len = 5'd22;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // header byte at position p of type k, zero past its end
    function automatic logic [7:0] hdr_byte(input t_type k, input t_hdr_pos p);
        logic [HDR_MAX_LEN*8-1:0] s;
        t_hdr_pos                 len;
        t_hdr_pos                 idx;
        logic [7:0]               b;
        case (k)
            TYPE_JPEG: s = HDR_STR_JPEG;
            TYPE_PNG:  s = HDR_STR_PNG;
            TYPE_GIF:  s = HDR_STR_GIF;
            TYPE_WEBP: s = HDR_STR_WEBP;
            TYPE_BMP:  s = HDR_STR_BMP;
            default:   s = '0;
        endcase
        len = hdr_len(k);
        b   = 8'h00;
        if (p < len) begin
            idx = len - 5'd1 - p;
            b   = s[{idx, 3'b000} +: 8];
        end
        return b;
    endfunction

    function automatic logic is_b64(input t_char c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9)) ||
               (c == CH_PLUS) || (c == CH_SLASH);
    endfunction

endpackage

`default_nettype wire

// ===== design/duiv_stream_if.sv =====
// valid/ready channel interfaces for characters in and verdicts out
`default_nettype none

interface duiv_char_if;
    import duiv_pkg::*;

    logic  valid;
    logic  ready;
    t_char character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface duiv_res_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== design/data_url_image_validator.sv =====
// streaming validator for inline image data urls, top level
//
// takes a data url one utf-16 code unit per transaction on i_char_ch, with
// last marking the final character, and returns one verdict transaction on
// o_res_ch per url: valid_res is 1 when the header folds (ascii only) to
// data:image/<jpeg|png|gif|webp|bmp>;base64, up to the first comma, the
// payload is a non-empty multiple of four made of base64 characters with at
// most two trailing '=' and at least one data character, and the total length
// is within max_chars. the block takes one character every clock cycle unless
// stalled; a character is held in the input register and checked against
// small match and counter registers; the verdict enters the result register
// as the last character leaves the input register. the input side stalls only
// when a verdict waits to be taken and the input register holds the last
// character of the next url. max_chars resets to 1500000 and is written by the
// user via i_cfg_we / i_cfg_wdata only between urls, unenforced by the block.
`default_nettype none

module data_url_image_validator (
    input  wire               i_clk,
    input  wire               i_rst_n,
    duiv_char_if.sink         i_char_ch,
    duiv_res_if.source        o_res_ch,
    input  wire               i_cfg_we,
    input  duiv_pkg::t_len    i_cfg_wdata
);
    import duiv_pkg::*;

    // input register
    logic     r_in_valid;
    t_char    r_in_char;
    logic     r_in_last;

    // result register
    logic     r_out_valid;
    logic     r_out_res;

    // configuration
    t_len     r_max_chars;

    // per-url scan state
    logic     r_in_payload;
    t_hdr_pos r_hdr_pos;
    t_cand    r_cand;
    t_len     r_total;
    logic     r_too_long;
    logic [1:0] r_mod4;
    logic     r_data_seen;
    logic [1:0] r_pad_cnt;
    logic     r_failed;

    logic     n_in_payload;
    t_hdr_pos n_hdr_pos;
    t_cand    n_cand;
    t_len     n_total;
    logic     n_too_long;
    logic [1:0] n_mod4;
    logic     n_data_seen;
    logic [1:0] n_pad_cnt;
    logic     n_failed;

    logic     w_out_free;
    logic     w_adv;
    logic     w_in_take;
    t_char    w_fold;
    logic     w_hdr_ok;
    logic     w_ok;

    // handshake: the input register drains unless a finished verdict blocks it
    assign w_out_free      = !r_out_valid || o_res_ch.ready;
    assign w_adv           = r_in_valid && (!r_in_last || w_out_free);
    assign i_char_ch.ready = !r_in_valid || w_adv;
    assign w_in_take       = i_char_ch.valid && i_char_ch.ready;

    // ascii upper case folded down for the header compare
    assign w_fold = ((r_in_char >= CH_UPPER_A) && (r_in_char <= CH_UPPER_Z)) ?
                    (r_in_char + CASE_DELTA) : r_in_char;

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_pos    = r_hdr_pos;
        n_cand       = r_cand;
        n_total      = r_total;
        n_too_long   = r_too_long;
        n_mod4       = r_mod4;
        n_data_seen  = r_data_seen;
        n_pad_cnt    = r_pad_cnt;
        n_failed     = r_failed;
        w_hdr_ok     = 1'b0;

        // saturating length count
        if (r_total == LENGTH_MAX) begin
            n_too_long = 1'b1;
        end else begin
            n_total = r_total + 1'b1;
        end

        if (!r_in_payload) begin
            if (r_in_char == CH_COMMA) begin
                // some surviving type must end exactly here
                for (int k = 0; k < TYPE_COUNT; k++) begin
                    if (r_cand[k] &&
                        ({1'b0, hdr_len(t_type'(k))} == ({1'b0, r_hdr_pos} + 6'd1))) begin
                        w_hdr_ok = 1'b1;
                    end
                end
                if (!w_hdr_ok) begin
                    n_failed = 1'b1;
                end
                n_in_payload = 1'b1;
            end else begin
                for (int k = 0; k < TYPE_COUNT; k++) begin
                    if ((r_hdr_pos >= hdr_len(t_type'(k))) ||
                        (w_fold != {8'h00, hdr_byte(t_type'(k), r_hdr_pos)})) begin
                        n_cand[k] = 1'b0;
                    end
                end
                if (r_hdr_pos != HDR_POS_MAX) begin
                    n_hdr_pos = r_hdr_pos + 1'b1;
                end
            end
        end else begin
            if (r_in_char == CH_EQUAL) begin
                // a third pad character fails
                if (r_pad_cnt >= 2'd2) begin
                    n_failed = 1'b1;
                end else begin
                    n_pad_cnt = r_pad_cnt + 1'b1;
                end
            end else begin
                // nothing but pad may follow pad
                if (r_pad_cnt != 2'd0) begin
                    n_failed = 1'b1;
                end
                if (is_b64(r_in_char)) begin
                    n_data_seen = 1'b1;
                end else begin
                    n_failed = 1'b1;
                end
            end
            n_mod4 = r_mod4 + 1'b1;
        end
    end

    // verdict from the state including the last character
    assign w_ok = !n_failed && n_in_payload && n_data_seen && (n_mod4 == 2'd0) &&
                  !n_too_long && (n_total <= r_max_chars);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_max_chars  <= MAX_CHARS_RESET;
            r_in_payload <= 1'b0;
            r_hdr_pos    <= '0;
            r_cand       <= '1;
            r_total      <= '0;
            r_too_long   <= 1'b0;
            r_mod4       <= 2'd0;
            r_data_seen  <= 1'b0;
            r_pad_cnt    <= 2'd0;
            r_failed     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_chars <= i_cfg_wdata;
            end

            // input register
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            // scan state: commit, or start over after the last character
            if (w_adv) begin
                if (r_in_last) begin
                    r_in_payload <= 1'b0;
                    r_hdr_pos    <= '0;
                    r_cand       <= '1;
                    r_total      <= '0;
                    r_too_long   <= 1'b0;
                    r_mod4       <= 2'd0;
                    r_data_seen  <= 1'b0;
                    r_pad_cnt    <= 2'd0;
                    r_failed     <= 1'b0;
                end else begin
                    r_in_payload <= n_in_payload;
                    r_hdr_pos    <= n_hdr_pos;
                    r_cand       <= n_cand;
                    r_total      <= n_total;
                    r_too_long   <= n_too_long;
                    r_mod4       <= n_mod4;
                    r_data_seen  <= n_data_seen;
                    r_pad_cnt    <= n_pad_cnt;
                    r_failed     <= n_failed;
                end
            end

            // result register
            if (w_adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_char_ch.character;
            r_in_last <= i_char_ch.last;
        end
        if (w_adv && r_in_last) begin
            r_out_res <= w_ok;
        end
    end

    assign o_res_ch.valid     = r_out_valid;
    assign o_res_ch.valid_res = r_out_res;

endmodule

`default_nettype wire

// ===== design/duiv_checker.sv =====
// port-level assertions for the data url image validator and their bind
`default_nettype none

`include "assert_macros.svh"

module duiv_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_in_last,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_res
);

    `DUIV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `DUIV_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_res))
    `DUIV_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)
    `DUIV_ASSERT_IMPLY(a_verdict_origin, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready && i_in_last, 2))

endmodule

bind data_url_image_validator duiv_checker u_duiv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char_ch.valid),
    .i_in_ready  (i_char_ch.ready),
    .i_in_last   (i_char_ch.last),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_out_res   (o_res_ch.valid_res)
);

`default_nettype wire

// ===== tb/sv/data_url_image_validator_test.sv =====
// self-checking testbench of the data url image validator, directed table then random urls
module data_url_image_validator_test;
    import duiv_pkg::*;

    localparam int     HALF_PERIOD  = 6;
    localparam int     RESET_CYCLES = 12;
    localparam int     RANDOM_CHARS = 1000;
    localparam int     PHASE_COUNT  = 9;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     REPORT_LIMIT = 10;
    localparam longint CYCLE_LIMIT  = 400000;

    // table markers: no override, no register write, verdict left to the predictor
    localparam int NO_WIDE = -1;
    localparam int NO_CFG  = -1;
    localparam int PREDICT = -1;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    t_len cfg_wdata;

    duiv_char_if char_ch ();
    duiv_res_if  res_ch ();

    data_url_image_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_ch   (char_ch),
        .o_res_ch    (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // predictor: own copy of the per-url match state and of max_chars
    // ------------------------------------------------------------------
    typedef struct {
        logic       in_payload;
        t_hdr_pos   hdr_pos;
        t_cand      alive;
        t_len       count;
        logic       over;
        logic [1:0] len_mod4;
        logic       has_data;
        logic [1:0] pads;
        logic       bad;
    } t_url_state;

    t_url_state url_st;
    t_len       max_chars_model;

    // expected verdicts in arrival order, and per-url pinned values from the table
    logic verdict_q[$];
    int   pinned_verdict_q[$];

    // characters of the url being built
    t_char url_buf[$];

    typedef struct {
        string text;
        int    wide_pos;
        int    wide_val;
        int    cfg;
        int    verdict;
    } t_dir_row;

    t_dir_row dir_rows[$];

    bit     idle_on;
    bit     hold_pending;
    int     stall_left;
    int     holds_done;
    int     mismatch_count;
    int     verdict_count;
    int     chars_sent;
    int     urls_sent;
    int     cfg_writes;
    longint cycle_count;

    logic has_v;
    logic pred_v;
    logic exp_v;
    int   pin;

    function automatic void clear_url();
        url_st.in_payload = 1'b0;
        url_st.hdr_pos    = '0;
        url_st.alive      = '1;
        url_st.count      = '0;
        url_st.over       = 1'b0;
        url_st.len_mod4   = '0;
        url_st.has_data   = 1'b0;
        url_st.pads       = '0;
        url_st.bad        = 1'b0;
    endfunction

    function automatic string header_text(input t_type k);
        case (k)
            TYPE_JPEG: return "data:image/jpeg;base64,";
            TYPE_PNG:  return "data:image/png;base64,";
            TYPE_GIF:  return "data:image/gif;base64,";
            TYPE_WEBP: return "data:image/webp;base64,";
            default:   return "data:image/bmp;base64,";
        endcase
    endfunction

    function automatic logic in_alphabet(input t_char c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
               c == CH_PLUS || c == CH_SLASH;
    endfunction

    // takes one accepted character, returns 1 when it closes a url
    function automatic logic absorb_char(input t_char c, input logic is_last,
                                         output logic verdict);
        t_char lc;
        logic  comma_ok;
        string hdr;
        verdict = 1'b0;
        // length counter saturates, one more character then marks the url too long
        if (url_st.count == LENGTH_MAX) begin
            url_st.over = 1'b1;
        end else begin
            url_st.count = url_st.count + 1'b1;
        end
        if (!url_st.in_payload) begin
            if (c == CH_COMMA) begin
                // header closes: some type must still match and end right here
                comma_ok = 1'b0;
                for (int k = 0; k < TYPE_COUNT; k++) begin
                    hdr = header_text(t_type'(k));
                    if (url_st.alive[k] && int'(url_st.hdr_pos) + 1 == hdr.len()) begin
                        comma_ok = 1'b1;
                    end
                end
                if (!comma_ok) begin
                    url_st.bad = 1'b1;
                end
                url_st.in_payload = 1'b1;
            end else begin
                // ascii-only case folding, wide code units pass unfolded
                lc = c;
                if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                    lc = c + CASE_DELTA;
                end
                for (int k = 0; k < TYPE_COUNT; k++) begin
                    hdr = header_text(t_type'(k));
                    if (int'(url_st.hdr_pos) >= hdr.len() ||
                        lc != {8'h00, hdr[url_st.hdr_pos]}) begin
                        url_st.alive[k] = 1'b0;
                    end
                end
                if (url_st.hdr_pos != HDR_POS_MAX) begin
                    url_st.hdr_pos = url_st.hdr_pos + 1'b1;
                end
            end
        end else begin
            if (c == CH_EQUAL) begin
                // a third pad character fails
                if (url_st.pads == 2'd2) begin
                    url_st.bad = 1'b1;
                end else begin
                    url_st.pads = url_st.pads + 1'b1;
                end
            end else begin
                // any non-pad character after padding fails
                if (url_st.pads != 2'd0) begin
                    url_st.bad = 1'b1;
                end
                if (in_alphabet(c)) begin
                    url_st.has_data = 1'b1;
                end else begin
                    url_st.bad = 1'b1;
                end
            end
            url_st.len_mod4 = url_st.len_mod4 + 1'b1;
        end
        if (!is_last) begin
            return 1'b0;
        end
        verdict = !url_st.bad && url_st.in_payload && url_st.has_data &&
                  url_st.len_mod4 == 2'd0 && !url_st.over &&
                  url_st.count <= max_chars_model;
        clear_url();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_char rand_b64();
        int r;
        r = $urandom_range(0, 63);
        if (r < 26) begin
            return CH_UPPER_A + t_char'(r);
        end else if (r < 52) begin
            return CH_LOWER_A + t_char'(r - 26);
        end else if (r < 62) begin
            return CH_DIGIT_0 + t_char'(r - 52);
        end else if (r == 62) begin
            return CH_PLUS;
        end
        return CH_SLASH;
    endfunction

    function automatic void load_text(input string s);
        url_buf.delete();
        for (int i = 0; i < s.len(); i++) begin
            url_buf.push_back({8'h00, s[i]});
        end
    endfunction

    function automatic void add_row(input string text, input int wide_pos, input int wide_val,
                                    input int cfg, input int verdict);
        t_dir_row r;
        r.text     = text;
        r.wide_pos = wide_pos;
        r.wide_val = wide_val;
        r.cfg      = cfg;
        r.verdict  = verdict;
        dir_rows.push_back(r);
    endfunction

    // mostly well-formed urls with random content, some with one defect, some pure noise
    function automatic void build_random_url();
        int    kind;
        int    quads;
        int    pads;
        int    pos;
        int    n;
        string hdr;
        t_char c;
        url_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            if ($urandom_range(0, 1) == 1) begin
                load_text("data:image/");
            end
            n = $urandom_range(1, 40);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       c = t_char'($urandom_range(0, 16'hFFFF));
                    1:       c = CH_COMMA;
                    2:       c = rand_b64();
                    default: c = t_char'($urandom_range(16'h0020, 16'h007E));
                endcase
                url_buf.push_back(c);
            end
            return;
        end
        hdr = header_text(t_type'($urandom_range(0, TYPE_COUNT - 1)));
        for (int i = 0; i < hdr.len(); i++) begin
            c = {8'h00, hdr[i]};
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(0, 3) == 0) begin
                c = c - CASE_DELTA;
            end
            url_buf.push_back(c);
        end
        quads = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        repeat (quads * 4) begin
            url_buf.push_back(rand_b64());
        end
        pads = $urandom_range(0, 2);
        for (int i = 0; i < pads; i++) begin
            url_buf[url_buf.size() - 1 - i] = CH_EQUAL;
        end
        if (kind >= 65) begin
            pos = $urandom_range(0, url_buf.size() - 1);
            case ($urandom_range(0, 7))
                0: url_buf[pos] = t_char'($urandom_range(0, 16'hFFFF));
                1: url_buf[pos] = t_char'($urandom_range(16'h0020, 16'h007E));
                2: url_buf.delete(pos);
                3: url_buf.insert(pos, CH_EQUAL);
                4: begin
                    while (url_buf.size() > pos + 1) begin
                        url_buf.delete(url_buf.size() - 1);
                    end
                end
                5: url_buf.push_back(rand_b64());
                6: begin
                    // wide code unit hiding an ascii low byte inside the header
                    pos = pos % hdr.len();
                    url_buf[pos] = url_buf[pos] | t_char'($urandom_range(1, 255) << 8);
                end
                default: url_buf.push_back(CH_EQUAL);
            endcase
        end
    endfunction

    // one character transaction, with an occasional idle burst before it
    task automatic send_char(input t_char c, input logic is_last);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.character <= c;
        char_ch.last      <= is_last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_url(input int verdict);
        pinned_verdict_q.push_back(verdict);
        for (int i = 0; i < url_buf.size(); i++) begin
            send_char(url_buf[i], i == url_buf.size() - 1);
        end
        urls_sent++;
    endtask

    // stop offering and wait until every verdict has been taken
    task automatic stop_and_drain();
        char_ch.valid <= 1'b0;
        while (verdict_q.size() != 0 || pinned_verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write only while the block is idle
    task automatic write_max_chars(input t_len v);
        stop_and_drain();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we          <= 1'b0;
        max_chars_model = v;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycle_count, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // verdict receiver: random stalls plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_pending) begin
                // long hold so the block backs up into the character side
                hold_pending = 1'b0;
                res_ch.ready <= 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                holds_done++;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                stall_left   = $urandom_range(0, 12);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each accepted character, check each verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && char_ch.ready) begin
                has_v = absorb_char(char_ch.character, char_ch.last, pred_v);
                if (has_v) begin
                    pin = pinned_verdict_q.pop_front();
                    verdict_q.push_back((pin == PREDICT) ? pred_v : pin[0]);
                end
            end
            if (res_ch.valid && res_ch.ready) begin
                verdict_count++;
                if (verdict_q.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("verdict %0b with no url pending, cycle %0d",
                                 res_ch.valid_res, cycle_count);
                    end
                    mismatch_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (res_ch.valid_res !== exp_v) begin
                        if (mismatch_count < REPORT_LIMIT) begin
                            $display("valid_res mismatch: expected %0b actual %0b, cycle %0d",
                                     exp_v, res_ch.valid_res, cycle_count);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_len phase_max[PHASE_COUNT];
        int   phase_end;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        char_ch.valid     = 1'b0;
        char_ch.character = '0;
        char_ch.last      = 1'b0;
        idle_on           = 1'b1;
        hold_pending      = 1'b0;
        max_chars_model   = MAX_CHARS_RESET;
        clear_url();

        // directed table, walked at the reset value of max_chars first
        add_row("data:image/png;base64,AAAA", NO_WIDE, 0, NO_CFG, 1);
        add_row("DaTa:ImAgE/JPEG;BaSe64,abcd", NO_WIDE, 0, NO_CFG, 1);
        add_row("data:image/gif;base64,AA==", NO_WIDE, 0, NO_CFG, 1);
        add_row("data:image/webp;base64,AAA=", NO_WIDE, 0, NO_CFG, 1);
        add_row("data:image/bmp;base64,+/09", NO_WIDE, 0, NO_CFG, 1);
        add_row("data:image/GIF;base64,Zm9v", NO_WIDE, 0, NO_CFG, PREDICT);
        // padding only, a third pad, data after padding
        add_row("data:image/png;base64,====", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/png;base64,A===", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/png;base64,A=A=", NO_WIDE, 0, NO_CFG, 0);
        // comma as last character, no comma at all, short payload
        add_row("data:image/png;base64,", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/png;base64", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/png;base64,AAA", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/tiff;base64,AAAA", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/pnga;base64,AAAA", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/png;base64,AA*A", NO_WIDE, 0, NO_CFG, 0);
        add_row("x", NO_WIDE, 0, NO_CFG, 0);
        add_row(",AAAA", NO_WIDE, 0, NO_CFG, 0);
        // header running past the saturating position, with and without a comma
        add_row("data:image/jpeg;base64;base64;base64", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/jpeg;base64;;;;;;;;;;;,AAAA", NO_WIDE, 0, NO_CFG, 0);
        // wide code units in the header and the character extremes in the payload
        add_row("data:image/png;base64,AAAA", 0, 16'h0164, NO_CFG, 0);
        add_row("data:image/png;base64,AAAA", 11, 16'hFF50, NO_CFG, 0);
        add_row("data:image/png;base64,AAAA", 5, 16'h0000, NO_CFG, 0);
        add_row("data:image/png;base64,AAAA", 22, 16'hFFFF, NO_CFG, 0);
        add_row("data:image/png;base64,AAAA", 25, 16'h0000, NO_CFG, 0);
        // length limit exactly met, then one over, then the extremes and zero
        add_row("data:image/png;base64,AAAA", NO_WIDE, 0, 26, 1);
        add_row("data:image/jpeg;base64,AAAA", NO_WIDE, 0, NO_CFG, 0);
        add_row("data:image/png;base64,AAAA", NO_WIDE, 0, 1, 0);
        add_row("data:image/jpeg;base64,/+9z", NO_WIDE, 0, int'(LENGTH_MAX), 1);
        add_row("data:image/png;base64,AAAA", NO_WIDE, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg != NO_CFG) begin
                write_max_chars(t_len'(dir_rows[i].cfg));
            end
            load_text(dir_rows[i].text);
            if (dir_rows[i].wide_pos != NO_WIDE) begin
                url_buf[dir_rows[i].wide_pos] = t_char'(dir_rows[i].wide_val);
            end
            send_url(dir_rows[i].verdict);
        end

        // random part, one max_chars setting per phase
        phase_max[0] = LENGTH_MAX;
        phase_max[1] = MAX_CHARS_RESET;
        phase_max[2] = t_len'(26);
        phase_max[3] = t_len'(27);
        phase_max[4] = t_len'($urandom_range(22, 40));
        phase_max[5] = t_len'($urandom_range(22, 40));
        phase_max[6] = t_len'(1);
        phase_max[7] = t_len'($urandom_range(1, int'(LENGTH_MAX)));
        phase_max[8] = LENGTH_MAX;

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_max_chars(phase_max[p]);
            if (p == 1) begin
                // receiver holds off while short urls keep coming
                hold_pending = 1'b1;
                repeat (12) begin
                    url_buf.delete();
                    url_buf.push_back(rand_b64());
                    send_url(PREDICT);
                end
            end
            // the last phase runs with no idling on either side
            if (p == PHASE_COUNT - 1) begin
                idle_on = 1'b0;
            end
            phase_end = chars_sent + RANDOM_CHARS / PHASE_COUNT;
            while (chars_sent < phase_end) begin
                build_random_url();
                send_url(PREDICT);
            end
        end

        stop_and_drain();

        $display("run covered %0d urls, %0d characters, %0d max_chars writes, %0d long holds",
                 urls_sent, chars_sent, cfg_writes, holds_done);
        $display("%0d verdicts checked, %0d mismatches", verdict_count, mismatch_count);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
